>>> rtl/core/lcsl_pkg.sv
// Package for the longest common substring length engine.
// Holds sizes, the request codes and the token that moves along the cell chain.
// No dependencies.
package lcsl_pkg;

  // Capacity of the reference store and width of one element
  localparam int MAX_LEN    = 1024;
  localparam int ELEM_WIDTH = 16;

  // Port field widths
  localparam int IN_ELEM_W  = 16;
  localparam int REQ_W      = 2;
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int IDX_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int OUT_DATA_W = ((LEN_W + 1 + 7) / 8) * 8;

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // Request codes carried on s_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  // One token per stage of the chain
  typedef struct packed {
    logic  vld;
    req_t  kind;
    elem_t elem;   // reference or query element
    idx_t  idx;    // target cell of a load
    len_t  diag;   // previous cell's length before this query
    len_t  best;   // running maximum of this query
    logic  ovf;    // overflow flag at the time the query entered
  } tok_t;

endpackage

>>> rtl/core/longest_common_substring_len.sv
// Top level of the longest common substring length engine.
// Depends on lcsl_pkg, lcsl_cell and lcsl_tail.
//
// Usage:
//   Input stream: s_tuser carries the request (clear, load, query), s_tdata the
//   element. A clear starts a job, loads append reference elements (those past
//   MAX_LEN are dropped and set the overflow flag), each query returns one result.
//   Output stream: m_tdata carries the best run length so far and the overflow flag.
//   Clears, loads and ignored request codes give no result.
// Timing:
//   Every clear, load and query that enters the chain walks MAX_LEN cells, one cell
//   per cycle while the chain moves; a query's result is then registered in the tail.
//   One transaction is accepted per cycle unless the chain holds; queries, loads and
//   clears may follow each other back to back, since each travels through the
//   cells in order. The reference count and overflow flag are kept at the chain entry.
// Reset and stall:
//   rst empties the store, zeroes every cell length and the best length.
//   When a result waits and m_tready is low, the whole chain holds and s_tready
//   drops until the result is taken.
module longest_common_substring_len (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lcsl_pkg::IN_ELEM_W-1:0]    s_tdata,   // [15:0] element
  input  logic [lcsl_pkg::REQ_W-1:0]        s_tuser,   // [1:0] req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lcsl_pkg::OUT_DATA_W-1:0]   m_tdata    // [10:0] best_length, [11] overflow
);

  logic           adv;
  logic           acc;
  lcsl_pkg::len_t count;
  lcsl_pkg::len_t count_next;
  logic           ovf;
  logic           ovf_next;
  lcsl_pkg::len_t out_best;
  logic           out_ovf;
  lcsl_pkg::tok_t entry_tok;
  lcsl_pkg::tok_t tok [lcsl_pkg::MAX_LEN+1];

  // Chain moves whenever the result register is free or being drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign acc      = s_tvalid && s_tready;

  // Entry: turn a transaction into a token, track count and overflow
  always_comb begin
    entry_tok  = '0;
    count_next = count;
    ovf_next   = ovf;
    if (acc) begin
      case (s_tuser)
        lcsl_pkg::REQ_CLEAR: begin
          entry_tok.vld  = 1'b1;
          entry_tok.kind = lcsl_pkg::REQ_CLEAR;
          count_next     = '0;
          ovf_next       = 1'b0;
        end
        lcsl_pkg::REQ_LOAD: begin
          if (count < lcsl_pkg::LEN_W'(lcsl_pkg::MAX_LEN)) begin
            entry_tok.vld  = 1'b1;
            entry_tok.kind = lcsl_pkg::REQ_LOAD;
            entry_tok.elem = lcsl_pkg::ELEM_WIDTH'(s_tdata);
            entry_tok.idx  = count[lcsl_pkg::IDX_W-1:0];
            count_next     = count + lcsl_pkg::LEN_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
        end
        lcsl_pkg::REQ_QUERY: begin
          entry_tok.vld  = 1'b1;
          entry_tok.kind = lcsl_pkg::REQ_QUERY;
          entry_tok.elem = lcsl_pkg::ELEM_WIDTH'(s_tdata);
          entry_tok.ovf  = ovf;
        end
        default: begin
        end
      endcase
    end
  end

  assign tok[0] = entry_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  // Row of cells
  for (genvar i = 0; i < lcsl_pkg::MAX_LEN; i++) begin : g_cell
    lcsl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .cell_index (lcsl_pkg::IDX_W'(i)),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  // Result stage
  lcsl_tail u_tail (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .tok_in   (tok[lcsl_pkg::MAX_LEN]),
    .out_vld  (m_tvalid),
    .out_best (out_best),
    .out_ovf  (out_ovf)
  );

  assign m_tdata = {{(lcsl_pkg::OUT_DATA_W - lcsl_pkg::LEN_W - 1){1'b0}}, out_ovf, out_best};

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= lcsl_pkg::LEN_W'(lcsl_pkg::MAX_LEN))
    else $error("reference count beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == lcsl_pkg::LEN_W'(lcsl_pkg::MAX_LEN)))
    else $error("overflow flagged with free store entries");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    (acc && (s_tuser == lcsl_pkg::REQ_CLEAR)) |=> (count == '0) && !ovf)
    else $error("clear did not empty the store");

endmodule

>>> rtl/core/lcsl_cell.sv
// One cell of the match-length chain: holds a reference element and its run length.
// Depends on lcsl_pkg.
module lcsl_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  lcsl_pkg::idx_t  cell_index,
  input  lcsl_pkg::tok_t  tok_in,
  output lcsl_pkg::tok_t  tok_out
);

  lcsl_pkg::elem_t ref_elem;
  logic            ref_vld;
  logic            ref_vld_next;
  lcsl_pkg::len_t  len;
  lcsl_pkg::len_t  len_next;
  lcsl_pkg::len_t  nv;
  lcsl_pkg::tok_t  tok_next;
  logic            load_here;

  assign load_here = tok_in.vld && (tok_in.kind == lcsl_pkg::REQ_LOAD) &&
                     (tok_in.idx == cell_index);

  // New length: diagonal plus one on a match, zero otherwise
  assign nv = (ref_vld && (ref_elem == tok_in.elem)) ?
              tok_in.diag + lcsl_pkg::LEN_W'(1) : '0;

  // Token update and cell state update
  always_comb begin
    tok_next     = tok_in;
    len_next     = len;
    ref_vld_next = ref_vld;
    if (tok_in.vld) begin
      case (tok_in.kind)
        lcsl_pkg::REQ_CLEAR: begin
          ref_vld_next = 1'b0;
          len_next     = '0;
        end
        lcsl_pkg::REQ_LOAD: begin
          if (load_here) begin
            ref_vld_next = 1'b1;
            len_next     = '0;
          end
        end
        lcsl_pkg::REQ_QUERY: begin
          len_next      = nv;
          tok_next.diag = len;
          tok_next.best = (nv > tok_in.best) ? nv : tok_in.best;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      ref_vld <= 1'b0;
      len     <= '0;
    end else if (adv) begin
      tok_out <= tok_next;
      ref_vld <= ref_vld_next;
      len     <= len_next;
    end
  end

  // Reference element, written by the load that targets this cell
  always_ff @(posedge clk) begin
    if (adv && load_here) begin
      ref_elem <= tok_in.elem;
    end
  end

endmodule

>>> rtl/core/lcsl_tail.sv
// Output stage at the end of the chain: job-wide best length and result register.
// Depends on lcsl_pkg.
module lcsl_tail (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  lcsl_pkg::tok_t  tok_in,
  output logic            out_vld,
  output lcsl_pkg::len_t  out_best,
  output logic            out_ovf
);

  lcsl_pkg::len_t best;
  lcsl_pkg::len_t merged;

  assign merged = (tok_in.best > best) ? tok_in.best : best;

  // Best length and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      best    <= '0;
    end else if (adv) begin
      out_vld <= tok_in.vld && (tok_in.kind == lcsl_pkg::REQ_QUERY);
      if (tok_in.vld) begin
        case (tok_in.kind)
          lcsl_pkg::REQ_CLEAR: best <= '0;
          lcsl_pkg::REQ_QUERY: best <= merged;
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (adv && tok_in.vld && (tok_in.kind == lcsl_pkg::REQ_QUERY)) begin
      out_best <= merged;
      out_ovf  <= tok_in.ovf;
    end
  end

endmodule
